// File: rtl/core/hsvp_pkg.sv
// HSV to packed RGBA converter: shared constants, sector helpers and sideband type.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package hsvp_pkg;

  localparam int HueW   = 15;
  localparam int ByteW  = 8;
  localparam int FracW  = 13;
  localparam int SwW    = 20;
  localparam int NumW   = 28;
  localparam int QuoW   = NumW - 8;
  localparam int RecipW = 21;
  localparam int ProdW  = QuoW + RecipW;
  localparam int RecipShift = 32;
  localparam int MaxSector  = 8;

  localparam logic [11:0]       SECTOR_STEPS = 12'd3840;
  // 255 * 3840
  localparam logic [SwW-1:0]    DEN          = 20'd979200;
  // ceil(2^32 / (15 * 255)), exact for quotients below 2^20
  localparam logic [RecipW-1:0] RECIP        = 21'd1122868;

  typedef logic [3:0] sector_t;

  localparam sector_t SEC_RED_YEL = 4'd0;
  localparam sector_t SEC_YEL_GRN = 4'd1;
  localparam sector_t SEC_GRN_CYN = 4'd2;
  localparam sector_t SEC_CYN_BLU = 4'd3;
  localparam sector_t SEC_BLU_MAG = 4'd4;

  typedef struct packed {
    sector_t          sector;
    logic             grey;
    logic [ByteW-1:0] val;
    logic [ByteW-1:0] alp;
    logic [ByteW-1:0] p;
  } side_t;

  function automatic sector_t sector_of(logic [HueW-1:0] hue);
    sector_t s;
    s = SEC_RED_YEL;
    for (int k = 1; k <= MaxSector; k++) begin
      if (hue >= HueW'(k * 3840)) s = sector_t'(k);
    end
    return s;
  endfunction

  function automatic logic [HueW-1:0] sector_base(sector_t s);
    return HueW'(s) * HueW'(SECTOR_STEPS);
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/hsvp_term.sv
// Pipelined q/t term: floor(V * (D - S*w) / D), three register stages.
// Depends on hsvp_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hsvp_term (
  input  wire                        clk,
  input  wire                        en,
  input  wire  [hsvp_pkg::ByteW-1:0] val,
  input  wire  [hsvp_pkg::ByteW-1:0] sat,
  input  wire  [hsvp_pkg::FracW-1:0] w,
  output logic [hsvp_pkg::ByteW-1:0] term
);
  import hsvp_pkg::*;

  logic [SwW-1:0]   sw;
  logic [ByteW-1:0] val_a;
  logic [NumW-1:0]  num;
  logic [ProdW-1:0] prod;

  always_ff @(posedge clk) begin
    if (en) begin
      sw    <= SwW'(sat) * SwW'(w);
      val_a <= val;
      num   <= NumW'(val_a) * NumW'(DEN - sw);
      // floor(floor(num/256) / 3825) == floor(num / D)
      prod  <= ProdW'(num[NumW-1:8]) * ProdW'(RECIP);
    end
  end

  assign term = prod[RecipShift +: ByteW];

endmodule

`default_nettype wire

// File: rtl/core/hsv_to_rgba_pack_core.sv
// HSV + alpha to packed RGBA word, six-stage pipeline.
// Depends on hsvp_pkg and hsvp_term.
//
//  channel | signals                                 | dir | beat
//  --------+-----------------------------------------+-----+---------------------------
//  hsv     | hue, saturation, value, alpha           | in  | hsv_valid & !hsv_stall
//  rgba    | packed_color                            | out | rgba_valid & !rgba_stall
//
// One beat per cycle unless the output is stalled; rgba_valid is the last stage valid.
// Stage depth is set by the q/t divide: multiply, multiply, reciprocal multiply.
// rst clears the stage valid bits only.
// The whole pipeline holds while the output beat is stalled; bubbles are not squeezed.
`timescale 1ns / 1ps
`default_nettype none

module hsv_to_rgba_pack_core (
  input  wire                         clk,
  input  wire                         rst,
  input  wire                         hsv_valid,
  output logic                        hsv_stall,
  input  wire  [hsvp_pkg::HueW-1:0]   hue,
  input  wire  [hsvp_pkg::ByteW-1:0]  saturation,
  input  wire  [hsvp_pkg::ByteW-1:0]  value,
  input  wire  [hsvp_pkg::ByteW-1:0]  alpha,
  output logic                        rgba_valid,
  input  wire                         rgba_stall,
  output logic [31:0]                 packed_color
);
  import hsvp_pkg::*;

  logic [5:0]       vld;
  logic             en;

  logic [HueW-1:0]  hue1;
  sector_t          sector1;
  logic [ByteW-1:0] sat1, val1, alp1;

  logic [11:0]      frac2;
  logic [FracW-1:0] fracc2;
  logic [15:0]      pn2;
  logic [ByteW-1:0] sat2;
  side_t            side2, side3, side4, side5;

  logic [11:0]      frac_next;
  logic [16:0]      p_sum;
  logic [ByteW-1:0] q_term, t_term;
  logic [ByteW-1:0] r_next, g_next, b_next;

  assign en         = !(vld[5] && rgba_stall);
  assign hsv_stall  = !en;
  assign rgba_valid = vld[5];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[4:0], hsv_valid};
    end
  end

  assign frac_next = 12'(hue1 - sector_base(sector1));
  assign p_sum     = 17'(pn2) + 17'(pn2[15:8]) + 17'd1;

  always_ff @(posedge clk) begin
    if (en) begin
      hue1    <= hue;
      sector1 <= sector_of(hue);
      sat1    <= saturation;
      val1    <= value;
      alp1    <= alpha;

      frac2  <= frac_next;
      fracc2 <= FracW'(SECTOR_STEPS) - FracW'(frac_next);
      pn2    <= 16'(val1) * {8'd0, ~sat1};
      sat2   <= sat1;
      side2  <= '{sector: sector1, grey: (sat1 == '0), val: val1, alp: alp1, p: '0};

      side3   <= '{sector: side2.sector, grey: side2.grey, val: side2.val, alp: side2.alp,
                   p: p_sum[15:8]};
      side4   <= side3;
      side5   <= side4;

      packed_color <= {r_next, g_next, b_next, side5.alp};
    end
  end

  hsvp_term u_q (
    .clk  (clk),
    .en   (en),
    .val  (side2.val),
    .sat  (sat2),
    .w    (FracW'(frac2)),
    .term (q_term)
  );

  hsvp_term u_t (
    .clk  (clk),
    .en   (en),
    .val  (side2.val),
    .sat  (sat2),
    .w    (fracc2),
    .term (t_term)
  );

  always_comb begin
    r_next = side5.val;
    g_next = side5.val;
    b_next = side5.val;
    if (!side5.grey) begin
      unique case (side5.sector)
        SEC_RED_YEL: begin
          r_next = side5.val; g_next = t_term;    b_next = side5.p;
        end
        SEC_YEL_GRN: begin
          r_next = q_term;    g_next = side5.val; b_next = side5.p;
        end
        SEC_GRN_CYN: begin
          r_next = side5.p;   g_next = side5.val; b_next = t_term;
        end
        SEC_CYN_BLU: begin
          r_next = side5.p;   g_next = q_term;    b_next = side5.val;
        end
        SEC_BLU_MAG: begin
          r_next = t_term;    g_next = side5.p;   b_next = side5.val;
        end
        default: begin
          r_next = side5.val; g_next = side5.p;   b_next = q_term;
        end
      endcase
    end
  end

  a_hold_on_stall: assert property (@(posedge clk) disable iff (rst)
    rgba_valid && rgba_stall |=> $stable(vld))
    else $error("pipeline moved while output beat stalled");

  a_frac_range: assert property (@(posedge clk) disable iff (rst)
    vld[1] |-> frac2 < SECTOR_STEPS && (13'(frac2) + fracc2) == 13'(SECTOR_STEPS))
    else $error("hue fraction out of sector");

  a_p_bound: assert property (@(posedge clk) disable iff (rst)
    vld[2] |-> side3.p <= side3.val)
    else $error("p term above value");

  a_qt_bound: assert property (@(posedge clk) disable iff (rst)
    vld[4] |-> q_term <= side5.val && t_term <= side5.val)
    else $error("q or t term above value");

  a_out_follows: assert property (@(posedge clk) disable iff (rst)
    vld[4] && en |=> rgba_valid)
    else $error("last stage beat lost");

endmodule

`default_nettype wire
